### rtl/uer_pkg.sv
`default_nettype none

package uer_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_PULSE  = 2'd2,
    PH_WAIT   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_WAIT_RISE = 2'd0,
    ST_WAIT_FALL = 2'd1,
    ST_COMPLETE  = 2'd2
  } echo_stage_t;

  typedef enum logic [1:0] {
    REG_SETTLE   = 2'd0,
    REG_PULSE    = 2'd1,
    REG_TIMEOUT  = 2'd2,
    REG_NO_ECHO  = 2'd3
  } reg_index_t;

  localparam int unsigned DIST_BITS = 11;
  localparam int unsigned REM_BITS  = 6;

  localparam logic [REM_BITS-1:0]  CM_DIVISOR     = 6'd59;
  localparam logic [7:0]           SETTLE_RESET   = 8'd4;
  localparam logic [7:0]           PULSE_RESET    = 8'd10;
  localparam logic [15:0]          TIMEOUT_RESET  = 16'd11800;
  localparam logic [DIST_BITS-1:0] NO_ECHO_RESET  = 11'd200;
  localparam logic [DIST_BITS-1:0] DIST_MAX       = '1;

endpackage

`default_nettype wire

### rtl/ultrasonic_echo_ranging.sv
// A result is registered and valid in the cycle after its input transaction is accepted.
// Throughput: one tick per cycle while the result stream accepts; the only limit is the single
// output register, which refills in the cycle it is drained.
// The echo width is divided by 59 incrementally while the echo is high.
// Reset (rst, synchronous, active high) returns the sequencer to idle, clears the
// counters and distance, and loads the configuration registers with their defaults.
`default_nettype none

module ultrasonic_echo_ranging #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] start_req, [1] echo_level, [7:2] zero
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [0] trigger_level, [1] busy_res, [2] done_res,
                                      // [13:3] distance_cm, [15:14] zero
  output logic [0:0]       m_tuser,   // [0] timed_out
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import uer_pkg::*;

  localparam int unsigned CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [7:0]           settle_ticks;
  logic [7:0]           pulse_ticks;
  logic [15:0]          timeout_ticks;
  logic [DIST_BITS-1:0] no_echo_distance;

  phase_t                  phase, phase_next;
  echo_stage_t             echo_stage, echo_stage_next;
  logic [COUNT_BITS-1:0]   tick_count, tick_count_next;
  logic [REM_BITS-1:0]     width_rem, width_rem_next;
  logic [DIST_BITS-1:0]    width_quo, width_quo_next;
  logic [DIST_BITS-1:0]    last_distance, last_distance_next;

  logic                    accept;
  logic                    start_req;
  logic                    echo_level;
  logic                    begin_meas;
  phase_t                  phase_eff;
  echo_stage_t             stage_base;
  logic [COUNT_BITS-1:0]   count_base;
  logic [COUNT_BITS-1:0]   count_inc;
  logic [CMP_BITS-1:0]     count_inc_ext;
  logic [CMP_BITS-1:0]     limit;
  logic                    rise_now;
  logic                    complete_now;
  logic                    timeout_hit;
  logic                    trigger_level;
  logic                    busy_res;
  logic                    done_res;
  logic                    timed_out;
  reg_index_t              cfg_index;
  logic                    cfg_write;

  assign pready    = 1'b1;
  assign cfg_index = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_index)
      REG_SETTLE:  prdata = {24'd0, settle_ticks};
      REG_PULSE:   prdata = {24'd0, pulse_ticks};
      REG_TIMEOUT: prdata = {16'd0, timeout_ticks};
      REG_NO_ECHO: prdata = {21'd0, no_echo_distance};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks     <= SETTLE_RESET;
      pulse_ticks      <= PULSE_RESET;
      timeout_ticks    <= TIMEOUT_RESET;
      no_echo_distance <= NO_ECHO_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SETTLE:  settle_ticks     <= pwdata[7:0];
        REG_PULSE:   pulse_ticks      <= pwdata[7:0];
        REG_TIMEOUT: timeout_ticks    <= pwdata[15:0];
        REG_NO_ECHO: no_echo_distance <= pwdata[DIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign start_req  = s_tdata[0];
  assign echo_level = s_tdata[1];

  // A start seen while idle is handled as the first settle tick.
  assign begin_meas = (phase == PH_IDLE) && start_req;
  assign phase_eff  = begin_meas ? PH_SETTLE : phase;
  assign count_base = begin_meas ? '0 : tick_count;
  assign stage_base = begin_meas ? ST_WAIT_RISE : echo_stage;
  assign count_inc  = (count_base == CountMax) ? count_base : count_base + 1'b1;
  assign count_inc_ext = CMP_BITS'(count_inc);

  assign limit = (CMP_BITS'(timeout_ticks) > CMP_BITS'(CountMax)) ?
                 CMP_BITS'(CountMax) : CMP_BITS'(timeout_ticks);

  assign rise_now     = (stage_base == ST_WAIT_RISE) && echo_level;
  assign complete_now = ((stage_base == ST_WAIT_FALL) && !echo_level) ||
                        (stage_base == ST_COMPLETE);
  assign timeout_hit  = count_inc_ext >= limit;

  // Next state: sequencer, tick counter, echo tracking and distance.
  always_comb begin
    phase_next         = phase_eff;
    tick_count_next    = count_inc;
    echo_stage_next    = stage_base;
    width_rem_next     = width_rem;
    width_quo_next     = width_quo;
    last_distance_next = last_distance;
    case (phase_eff)
      PH_SETTLE: begin
        if (count_inc_ext >= CMP_BITS'(settle_ticks)) begin
          phase_next      = PH_PULSE;
          tick_count_next = '0;
        end
      end
      PH_PULSE: begin
        if (count_inc_ext >= CMP_BITS'(pulse_ticks)) begin
          phase_next      = PH_WAIT;
          tick_count_next = '0;
        end
      end
      PH_WAIT: begin
        // The echo width is kept as quotient and remainder by 59, so the
        // distance is ready on the falling tick.
        if (rise_now) begin
          echo_stage_next = ST_WAIT_FALL;
          width_quo_next  = '0;
          width_rem_next  = REM_BITS'(1);
        end else if ((stage_base == ST_WAIT_FALL) && !echo_level) begin
          echo_stage_next = ST_COMPLETE;
        end else if (stage_base == ST_WAIT_FALL) begin
          if (width_rem == CM_DIVISOR - 1'b1) begin
            width_rem_next = '0;
            if (width_quo != DIST_MAX) begin
              width_quo_next = width_quo + 1'b1;
            end
          end else begin
            width_rem_next = width_rem + 1'b1;
          end
        end
        if (complete_now) begin
          last_distance_next = width_quo;
          phase_next         = PH_IDLE;
        end else if (timeout_hit) begin
          last_distance_next = no_echo_distance;
          phase_next         = PH_IDLE;
        end
      end
      default: begin
        tick_count_next = tick_count;
      end
    endcase
  end

  // Result flags for the current tick.
  always_comb begin
    trigger_level = (phase_eff == PH_PULSE);
    busy_res      = (phase_eff != PH_IDLE);
    done_res      = (phase_eff == PH_WAIT) && (complete_now || timeout_hit);
    timed_out     = (phase_eff == PH_WAIT) && !complete_now && timeout_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      echo_stage    <= ST_WAIT_RISE;
      tick_count    <= '0;
      width_rem     <= '0;
      width_quo     <= '0;
      last_distance <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        echo_stage    <= echo_stage_next;
        tick_count    <= tick_count_next;
        width_rem     <= width_rem_next;
        width_quo     <= width_quo_next;
        last_distance <= last_distance_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, last_distance_next, done_res, busy_res, trigger_level};
      m_tuser <= timed_out;
    end
  end

`ifndef ASSERT_OFF
  a_timeout_has_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[2])
    else $error("timeout reported without done");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (rst)
    accept && done_res |=> phase == PH_IDLE)
    else $error("sequencer not idle after a finished measurement");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    width_rem < CM_DIVISOR)
    else $error("echo width remainder out of range");
`endif

endmodule

`default_nettype wire
